@@ design/infix_to_postfix_converter_macros.svh @@
// Assertion macros for the checker of the infix-to-postfix converter.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define IFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

@@ design/ifp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_pkg
// Types, character codes and decode functions of the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package ifp_pkg;

	// ASCII codes of interest.
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CH_POW     = 8'h5E;
	localparam logic [7:0] CH_DIV     = 8'h2F;
	localparam logic [7:0] CH_MUL     = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LPAR    = 8'h28;
	localparam logic [7:0] CH_RPAR    = 8'h29;
	localparam logic [7:0] CH_TERM    = 8'h00;

	// Code of one operator stack entry.
	typedef enum logic [2:0] {
		OP_LPAR  = 3'd0,
		OP_PLUS  = 3'd1,
		OP_MINUS = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_POW   = 3'd5
	} op_t;

	// What the current character asks of the sequencer.
	typedef enum logic [2:0] {
		MODE_LETTER,
		MODE_LPAR,
		MODE_OP,
		MODE_RPAR,
		MODE_IGNORE,
		MODE_FLUSH
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_DONE
	} state_t;

	// Request from the sequencer to the output stage.
	typedef struct packed {
		logic       emit;
		logic       close;
		logic [7:0] sym;
		logic       term;
		logic       fault;
	} out_ctl_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       terminator;
		logic       fault;
		logic       run_end;
	} out_word_t;

	function automatic mode_t char_mode(input logic [7:0] c);
		mode_t m;
		m = MODE_IGNORE;
		if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
			m = MODE_LETTER;
		end else begin
			unique case (c)
				CH_LPAR: m = MODE_LPAR;
				CH_RPAR: m = MODE_RPAR;
				CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW: m = MODE_OP;
				default: m = MODE_IGNORE;
			endcase
		end
		return m;
	endfunction

	function automatic op_t char_op(input logic [7:0] c);
		op_t o;
		unique case (c)
			CH_PLUS:  o = OP_PLUS;
			CH_MINUS: o = OP_MINUS;
			CH_MUL:   o = OP_MUL;
			CH_DIV:   o = OP_DIV;
			CH_POW:   o = OP_POW;
			default:  o = OP_LPAR;
		endcase
		return o;
	endfunction

	function automatic logic [7:0] op_char(input op_t o);
		logic [7:0] c;
		unique case (o)
			OP_LPAR:  c = CH_LPAR;
			OP_PLUS:  c = CH_PLUS;
			OP_MINUS: c = CH_MINUS;
			OP_MUL:   c = CH_MUL;
			OP_DIV:   c = CH_DIV;
			OP_POW:   c = CH_POW;
			default:  c = CH_TERM;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] op_prec(input op_t o);
		logic [1:0] p;
		unique case (o)
			OP_PLUS, OP_MINUS: p = 2'd1;
			OP_MUL, OP_DIV:    p = 2'd2;
			OP_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ design/ifp_infix_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_infix_if
// Valid/ready channel that carries one infix character word.
// ----------------------------------------------------------------------------
interface ifp_infix_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       final_char;

	modport source (output valid, output symbol, output final_char, input ready);
	modport sink (input valid, input symbol, input final_char, output ready);
endinterface
`default_nettype wire

@@ design/ifp_postfix_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_postfix_if
// Valid/ready channel that carries one postfix result word.
// ----------------------------------------------------------------------------
interface ifp_postfix_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       terminator;
	logic       fault;
	logic       run_end;

	modport source (output valid, output out_symbol, output terminator, output fault,
		output run_end, input ready);
	modport sink (input valid, input out_symbol, input terminator, input fault,
		input run_end, output ready);
endinterface
`default_nettype wire

@@ design/ifp_stack_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_stack_mem
// Operator stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ifp_stack_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [2:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [2:0]    rdata
);

	logic [2:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/ifp_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_out_stage
// Holds the newest result until the next one or the end of the character is
// known, then moves it into the output register with its run_end bit.
// ----------------------------------------------------------------------------
module ifp_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifp_pkg::out_ctl_t    ctl,
	output logic                 room,
	output logic                 valid,
	input  logic                 ready,
	output ifp_pkg::out_word_t   word
);

	logic               pend_valid_q;
	logic [7:0]         pend_sym_q;
	logic               pend_term_q;
	logic               pend_fault_q;
	logic               out_valid_q;
	ifp_pkg::out_word_t out_q;
	logic               out_free;
	logic               load_out;

	assign out_free = !out_valid_q || ready;
	assign room     = !pend_valid_q || out_free;
	assign load_out = pend_valid_q && out_free && (ctl.emit || ctl.close);
	assign valid    = out_valid_q;
	assign word     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.emit) begin
				pend_valid_q <= 1'b1;
			end else if (load_out) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			pend_sym_q   <= ctl.sym;
			pend_term_q  <= ctl.term;
			pend_fault_q <= ctl.fault;
		end
		if (load_out) begin
			out_q.out_symbol <= pend_sym_q;
			out_q.terminator <= pend_term_q;
			out_q.fault      <= pend_fault_q;
			out_q.run_end    <= ctl.close;
		end
	end

endmodule
`default_nettype wire

@@ design/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from infix characters to postfix characters.
// ----------------------------------------------------------------------------
// The block takes one infix character word at a time and returns its postfix
// result words. Letters pass straight through, operators wait on a stack of
// STACK_DEPTH entries and leave it by precedence, and the word marked
// final_char flushes the stack and ends with a terminator word (out_symbol 0).
// run_end marks the last result word of each input word; fault is a sticky
// flag for unmatched parentheses and stack overflow that only reset clears.
// One character is worked on at a time. A character is accepted in ST_IDLE,
// evaluated in ST_EVAL and closed in ST_DONE, whether it gives a result or
// not, and it stays in ST_EVAL while it pops operators; a final character
// also passes ST_READ for a stack re-read, pops every entry left on the
// stack and gives the terminator word. A word that is due while the output
// register is still held by the consumer waits in ST_EVAL or ST_DONE. Each
// pop reads the next stack entry from the synchronous stack memory, which
// returns it in the next cycle. The newest result is held back one step
// until it is known whether it is the last of its character, and a
// separate output register lets the next character be taken while the
// last word still waits for the consumer.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ifp_infix_if.sink            infix,
	ifp_postfix_if.source        postfix
);

	// Count must hold STACK_DEPTH itself; addresses only reach STACK_DEPTH-1.
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	ifp_pkg::state_t    state_q, state_d;
	ifp_pkg::mode_t     mode_q;
	logic [7:0]         sym_q;
	logic               fin_q;
	ifp_pkg::op_t       opc_q;
	logic [CW-1:0]      count_q;
	logic               err_q;

	logic [2:0]         rd_data;
	ifp_pkg::op_t       top_op;
	logic               has_top;
	logic               full;
	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cnt_m2;
	logic               accept;

	// Decisions for the character under work in ST_EVAL.
	logic               emit_req;
	logic [7:0]         emit_sym;
	logic               emit_term;
	logic               pop_req;
	logic               push_req;
	ifp_pkg::op_t       push_code;
	logic               err_req;
	logic               step_fin;
	logic               go;
	logic               step_end;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [2:0]         mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	ifp_pkg::out_ctl_t  ctl;
	logic               room;
	ifp_pkg::out_word_t word;

	// The stack top is whatever the memory returned for entry count-1.
	assign top_op  = ifp_pkg::op_t'(rd_data);
	assign has_top = (count_q != '0);
	assign full    = (count_q >= CW'(STACK_DEPTH));
	assign cnt_m1  = count_q - CW'(1);
	assign cnt_m2  = count_q - CW'(2);
	assign accept  = infix.valid && infix.ready;

	always_comb begin
		emit_req  = 1'b0;
		emit_sym  = ifp_pkg::CH_TERM;
		emit_term = 1'b0;
		pop_req   = 1'b0;
		push_req  = 1'b0;
		push_code = ifp_pkg::OP_LPAR;
		err_req   = 1'b0;
		step_fin  = 1'b0;
		case (mode_q)
			ifp_pkg::MODE_LETTER: begin
				emit_req = 1'b1;
				emit_sym = sym_q;
				step_fin = 1'b1;
			end
			ifp_pkg::MODE_LPAR: begin
				push_req = 1'b1;
				step_fin = 1'b1;
			end
			ifp_pkg::MODE_OP: begin
				// Pop while the top binds at least as tightly as the newcomer.
				if (has_top && top_op != ifp_pkg::OP_LPAR &&
					ifp_pkg::op_prec(top_op) >= ifp_pkg::op_prec(opc_q)) begin
					emit_req = 1'b1;
					emit_sym = ifp_pkg::op_char(top_op);
					pop_req  = 1'b1;
				end else begin
					push_req  = 1'b1;
					push_code = opc_q;
					step_fin  = 1'b1;
				end
			end
			ifp_pkg::MODE_RPAR: begin
				if (has_top && top_op != ifp_pkg::OP_LPAR) begin
					emit_req = 1'b1;
					emit_sym = ifp_pkg::op_char(top_op);
					pop_req  = 1'b1;
				end else if (has_top) begin
					// Matching opening parenthesis is dropped.
					pop_req  = 1'b1;
					step_fin = 1'b1;
				end else begin
					err_req  = 1'b1;
					step_fin = 1'b1;
				end
			end
			ifp_pkg::MODE_FLUSH: begin
				if (has_top) begin
					pop_req = 1'b1;
					if (top_op == ifp_pkg::OP_LPAR) begin
						err_req = 1'b1;
					end else begin
						emit_req = 1'b1;
						emit_sym = ifp_pkg::op_char(top_op);
					end
				end else begin
					emit_req  = 1'b1;
					emit_term = 1'b1;
					step_fin  = 1'b1;
				end
			end
			default: begin
				step_fin = 1'b1;
			end
		endcase
	end

	// Nothing happens in a cycle whose result finds no room downstream.
	assign go       = (state_q == ifp_pkg::ST_EVAL) && (!emit_req || room);
	assign step_end = go && step_fin;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ifp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ifp_pkg::ST_EVAL;
				end
			end
			ifp_pkg::ST_EVAL: begin
				if (step_end) begin
					if (fin_q && mode_q != ifp_pkg::MODE_FLUSH) begin
						state_d = ifp_pkg::ST_READ;
					end else begin
						state_d = ifp_pkg::ST_DONE;
					end
				end
			end
			ifp_pkg::ST_READ: begin
				state_d = ifp_pkg::ST_EVAL;
			end
			ifp_pkg::ST_DONE: begin
				if (room) begin
					state_d = ifp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ifp_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer. A push is always followed by ST_READ or ST_DONE
	// before the stack is read again, so a read never meets a write to the
	// same entry in one cycle.
	always_comb begin
		infix.ready = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = cnt_m1[AW-1:0];
		unique case (state_q)
			ifp_pkg::ST_IDLE: begin
				infix.ready = 1'b1;
				mem_re      = has_top;
			end
			ifp_pkg::ST_READ: begin
				mem_re = has_top;
			end
			ifp_pkg::ST_EVAL: begin
				mem_re    = go && pop_req && (count_q > CW'(1));
				mem_raddr = cnt_m2[AW-1:0];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
		mem_we    = go && push_req && !full;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = push_code;
		ctl.emit  = go && emit_req;
		ctl.close = (state_q == ifp_pkg::ST_DONE);
		ctl.sym   = emit_sym;
		ctl.term  = emit_term;
		ctl.fault = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifp_pkg::ST_IDLE;
			mode_q  <= ifp_pkg::MODE_IGNORE;
			fin_q   <= 1'b0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= ifp_pkg::char_mode(infix.symbol);
				fin_q  <= infix.final_char;
			end else if (step_end && fin_q && mode_q != ifp_pkg::MODE_FLUSH) begin
				mode_q <= ifp_pkg::MODE_FLUSH;
			end
			if (go && pop_req) begin
				count_q <= cnt_m1;
			end else if (go && push_req && !full) begin
				count_q <= count_q + CW'(1);
			end
			// A push onto a full stack is dropped and flagged.
			if (go && (err_req || (push_req && full))) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= infix.symbol;
			opc_q <= ifp_pkg::char_op(infix.symbol);
		end
	end

	ifp_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	ifp_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.room   (room),
		.valid  (postfix.valid),
		.ready  (postfix.ready),
		.word   (word)
	);

	assign postfix.out_symbol = word.out_symbol;
	assign postfix.terminator = word.terminator;
	assign postfix.fault      = word.fault;
	assign postfix.run_end    = word.run_end;

endmodule
`default_nettype wire

@@ design/ifp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_checker
// Port-level checks of the infix-to-postfix converter, bound to its top level.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_macros.svh"

module ifp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic       terminator,
	input logic       fault,
	input logic       run_end
);

	`IFP_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "postfix valid dropped while stalled")
	`IFP_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out_symbol) && $stable(terminator) && $stable(fault) && $stable(run_end), "postfix word changed while stalled")
	`IFP_ASSERT(a_term_ends_run, out_valid && terminator |-> run_end && out_symbol == 8'd0, "terminator word is not a closing zero word")
	`IFP_ASSERT_NEXT(a_fault_sticky, out_valid && out_ready && fault, !out_valid || fault, "fault flag cleared after being reported")
	`IFP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "new word taken in the cycle after an accept")

endmodule

bind infix_to_postfix_converter ifp_checker u_ifp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (infix.valid),
	.in_ready   (infix.ready),
	.out_valid  (postfix.valid),
	.out_ready  (postfix.ready),
	.out_symbol (postfix.out_symbol),
	.terminator (postfix.terminator),
	.fault      (postfix.fault),
	.run_end    (postfix.run_end)
);
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
// Infix character words are fed through the input channel. Every accepted
// word is run through a shunting-yard predictor kept in this file, and the
// postfix words that the block returns are checked, field by field, against
// the oldest prediction. The run has four phases that change how often the
// sender idles and how often the receiver stalls. It opens with hand-picked
// expressions and then goes on to random well-formed expressions, broken
// sequences, noise, and one nest deep enough to overflow the stack.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STACK_DEPTH  = 32;
	// This limit only catches a hung block.
	localparam int CYCLE_LIMIT  = 1000000;
	// This wait covers any result that comes late.
	localparam int SETTLE_WAIT  = 64;
	localparam int PHASE_ITEMS  = 80;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [7:0] symbol;
		logic       is_last;
	} infix_word_t;

	logic clk;
	logic arst_n;

	ifp_infix_if   infix_ch();
	ifp_postfix_if postfix_ch();

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.infix(infix_ch),
		.postfix(postfix_ch)
	);

	// Words still to be sent, filled a whole phase at a time.
	infix_word_t        pending_chars[$];
	// Postfix words that the block still owes, oldest first.
	ifp_pkg::out_word_t results_due[$];

	// Shadow of the block's state, updated as each word is accepted.
	ifp_pkg::op_t       op_stack[STACK_DEPTH];
	int                 stack_fill;
	logic               fault_flag;

	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 item_count;
	int                 mismatch_count;
	int                 result_count;
	int                 cycle_count;
	logic               word_taken;
	ifp_pkg::out_word_t seen_word;
	ifp_pkg::out_word_t due_word;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Binding strength of a stacked entry. An opening parenthesis gets the
	// lowest value, but the pop loops stop on it before comparing anyway.
	function automatic logic [1:0] rank(input ifp_pkg::op_t entry);
		case (entry)
			ifp_pkg::OP_POW:                     return 2'd3;
			ifp_pkg::OP_MUL, ifp_pkg::OP_DIV:    return 2'd2;
			ifp_pkg::OP_PLUS, ifp_pkg::OP_MINUS: return 2'd1;
			default:                             return 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] glyph(input ifp_pkg::op_t entry);
		case (entry)
			ifp_pkg::OP_PLUS:  return ifp_pkg::CH_PLUS;
			ifp_pkg::OP_MINUS: return ifp_pkg::CH_MINUS;
			ifp_pkg::OP_MUL:   return ifp_pkg::CH_MUL;
			ifp_pkg::OP_DIV:   return ifp_pkg::CH_DIV;
			ifp_pkg::OP_POW:   return ifp_pkg::CH_POW;
			default:           return ifp_pkg::CH_LPAR;
		endcase
	endfunction

	// The fault bit is the sticky flag as it stands when the word is made.
	function automatic void add_result(input logic [7:0] sym, input logic term);
		results_due.push_back('{out_symbol: sym, terminator: term, fault: fault_flag,
			run_end: 1'b0});
	endfunction

	// A push onto a full stack is dropped and raises the sticky flag.
	function automatic void push_entry(input ifp_pkg::op_t entry);
		if (stack_fill >= STACK_DEPTH) begin
			fault_flag = 1'b1;
		end else begin
			op_stack[stack_fill] = entry;
			stack_fill++;
		end
	endfunction

	// Works out the postfix words caused by one accepted infix word.
	task automatic convert_word(input logic [7:0] c, input logic is_last);
		int           queued_before;
		ifp_pkg::op_t incoming;
		logic         is_op;
		queued_before = results_due.size();
		is_op = 1'b1;
		incoming = ifp_pkg::OP_LPAR;
		case (c)
			ifp_pkg::CH_PLUS:  incoming = ifp_pkg::OP_PLUS;
			ifp_pkg::CH_MINUS: incoming = ifp_pkg::OP_MINUS;
			ifp_pkg::CH_MUL:   incoming = ifp_pkg::OP_MUL;
			ifp_pkg::CH_DIV:   incoming = ifp_pkg::OP_DIV;
			ifp_pkg::CH_POW:   incoming = ifp_pkg::OP_POW;
			default:           is_op = 1'b0;
		endcase

		if ((c >= ifp_pkg::CH_UPPER_A && c <= ifp_pkg::CH_UPPER_Z) ||
				(c >= ifp_pkg::CH_LOWER_A && c <= ifp_pkg::CH_LOWER_Z)) begin
			add_result(c, 1'b0);
		end else if (c == ifp_pkg::CH_LPAR) begin
			push_entry(ifp_pkg::OP_LPAR);
		end else if (is_op) begin
			// Equal precedence pops too, which makes every operator
			// left-associative, the power operator included.
			while (stack_fill > 0 && op_stack[stack_fill - 1] != ifp_pkg::OP_LPAR &&
					rank(op_stack[stack_fill - 1]) >= rank(incoming)) begin
				add_result(glyph(op_stack[stack_fill - 1]), 1'b0);
				stack_fill--;
			end
			push_entry(incoming);
		end else if (c == ifp_pkg::CH_RPAR) begin
			while (stack_fill > 0 && op_stack[stack_fill - 1] != ifp_pkg::OP_LPAR) begin
				add_result(glyph(op_stack[stack_fill - 1]), 1'b0);
				stack_fill--;
			end
			// With no opening parenthesis left, the close is unmatched.
			if (stack_fill > 0) begin
				stack_fill--;
			end else begin
				fault_flag = 1'b1;
			end
		end

		// The final word flushes the stack. An opening parenthesis found
		// there is unmatched: it is dropped and raises the flag.
		if (is_last) begin
			while (stack_fill > 0) begin
				if (op_stack[stack_fill - 1] == ifp_pkg::OP_LPAR) begin
					fault_flag = 1'b1;
				end else begin
					add_result(glyph(op_stack[stack_fill - 1]), 1'b0);
				end
				stack_fill--;
			end
			add_result(ifp_pkg::CH_TERM, 1'b1);
		end

		if (results_due.size() > queued_before) begin
			results_due[$].run_end = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// A character that the block acts on; counts toward the phase size.
	function automatic void add_char(input logic [7:0] sym);
		pending_chars.push_back('{symbol: sym, is_last: 1'b0});
		item_count++;
	endfunction

	// A character that is likely ignored; it does not count.
	function automatic void add_noise(input logic [7:0] sym);
		pending_chars.push_back('{symbol: sym, is_last: 1'b0});
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(1) == 0) begin
			return 8'($urandom_range(ifp_pkg::CH_UPPER_A, ifp_pkg::CH_UPPER_Z));
		end
		return 8'($urandom_range(ifp_pkg::CH_LOWER_A, ifp_pkg::CH_LOWER_Z));
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(4))
			0:       return ifp_pkg::CH_PLUS;
			1:       return ifp_pkg::CH_MINUS;
			2:       return ifp_pkg::CH_MUL;
			3:       return ifp_pkg::CH_DIV;
			default: return ifp_pkg::CH_POW;
		endcase
	endfunction

	// Space, a digit, or a byte with the top bit set: all of them ignored.
	function automatic logic [7:0] ignored_char();
		case ($urandom_range(2))
			0:       return 8'h20;
			1:       return 8'h30 + 8'($urandom_range(9));
			default: return 8'h80 | 8'($urandom_range(127));
		endcase
	endfunction

	// A well-formed expression with random content, nesting up to six
	// levels, with the odd ignored character mixed in. Its last word is
	// marked final.
	task automatic add_expression();
		int operands;
		int open_pars;
		int k;
		operands = $urandom_range(1, 10);
		open_pars = 0;
		for (k = 0; k < operands; k++) begin
			while (open_pars < 6 && $urandom_range(3) == 0) begin
				add_char(ifp_pkg::CH_LPAR);
				open_pars++;
			end
			add_char(random_letter());
			if ($urandom_range(11) == 0) begin
				add_noise(ignored_char());
			end
			if (k == operands - 1) begin
				repeat (open_pars) add_char(ifp_pkg::CH_RPAR);
				open_pars = 0;
			end else begin
				while (open_pars > 0 && $urandom_range(2) == 0) begin
					add_char(ifp_pkg::CH_RPAR);
					open_pars--;
				end
				add_char(random_operator());
			end
		end
		// Now and then the expression ends on an ignored final word.
		if ($urandom_range(7) == 0) begin
			add_noise(ignored_char());
		end
		pending_chars[$].is_last = 1'b1;
	endtask

	// A short run of arbitrary characters, final or not. Unfinished runs
	// leave their stack to the next expression.
	task automatic add_broken();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(5))
				0:       add_char(random_letter());
				1:       add_char(random_operator());
				2:       add_char(ifp_pkg::CH_LPAR);
				3:       add_char(ifp_pkg::CH_RPAR);
				default: add_noise(8'($urandom_range(255)));
			endcase
		end
		if ($urandom_range(1) == 1) begin
			pending_chars[$].is_last = 1'b1;
		end
	endtask

	// Returns once nothing is left to send and nothing is owed.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_chars.size() != 0 || infix_ch.valid || results_due.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Driver: presents the next pending word at the falling edge, holds it
	// until it is taken, and idles at random between words.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			infix_ch.valid   <= 1'b0;
			postfix_ch.ready <= 1'b0;
		end else begin
			if (!infix_ch.valid || word_taken) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					infix_ch.valid      <= 1'b1;
					infix_ch.symbol     <= pending_chars[0].symbol;
					infix_ch.final_char <= pending_chars[0].is_last;
					void'(pending_chars.pop_front());
				end else begin
					infix_ch.valid <= 1'b0;
				end
			end
			postfix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. The input side
	// feeds the predictor first, then any result word is checked against
	// the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			word_taken <= infix_ch.valid && infix_ch.ready;
			if (infix_ch.valid && infix_ch.ready) begin
				convert_word(infix_ch.symbol, infix_ch.final_char);
			end
			if (postfix_ch.valid && postfix_ch.ready) begin
				seen_word = '{out_symbol: postfix_ch.out_symbol,
					terminator: postfix_ch.terminator, fault: postfix_ch.fault,
					run_end: postfix_ch.run_end};
				if (results_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display({"result word %0d arrived with none expected: ",
							"sym %h term %b fault %b end %b"},
							result_count, seen_word.out_symbol, seen_word.terminator,
							seen_word.fault, seen_word.run_end);
					end
				end else begin
					due_word = results_due.pop_front();
					if (seen_word.out_symbol !== due_word.out_symbol ||
							seen_word.terminator !== due_word.terminator ||
							seen_word.fault !== due_word.fault ||
							seen_word.run_end !== due_word.run_end) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display({"result word %0d: expected sym %h term %b fault %b ",
								"end %b, got sym %h term %b fault %b end %b"},
								result_count, due_word.out_symbol, due_word.terminator,
								due_word.fault, due_word.run_end, seen_word.out_symbol,
								seen_word.terminator, seen_word.fault, seen_word.run_end);
						end
					end
				end
				result_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		int phase;
		infix_ch.valid      = 1'b0;
		infix_ch.symbol     = 8'h00;
		infix_ch.final_char = 1'b0;
		postfix_ch.ready    = 1'b0;
		arst_n              = 1'b0;
		stack_fill          = 0;
		fault_flag          = 1'b0;
		word_taken          = 1'b0;
		mismatch_count      = 0;
		result_count        = 0;
		cycle_count         = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		item_count          = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// First phase, with no idling on either side. The hand-picked
		// expressions touch the letter extremes, every operator at every
		// precedence, parentheses, left associativity of equal operators
		// (the power operator too), and ignored words, among them a run of
		// ignored words that ends in the final word. None of them raises the
		// sticky flag, so fault stays low until the second phase.
		add_text("a+Z*(b-z)/A^c");
		pending_chars[$].is_last = 1'b1;
		add_text("x^y^z");
		pending_chars[$].is_last = 1'b1;
		add_text("A-B+C");
		pending_chars[$].is_last = 1'b1;
		add_noise(8'h00);
		add_noise(8'hFF);
		pending_chars[$].is_last = 1'b1;
		while (item_count < PHASE_ITEMS) add_expression();
		wait_drained();

		// Each later phase starts from a drained block, which is also the
		// point where the sender holds off until every owed word is in.
		for (phase = 1; phase <= 3; phase++) begin
			item_count = 0;
			case (phase)
				1: begin
					send_idle_pct  = 70;
					recv_stall_pct = 0;
					// An unmatched close that still pops an operator, then
					// an unmatched open that the flush discards.
					add_text("a*b)");
					add_text("(c-d");
					pending_chars[$].is_last = 1'b1;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 70;
					// A nest past the stack depth, with pending operators
					// mixed in, so pushes are dropped and the flush is long.
					repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 8)) begin
						if ($urandom_range(2) == 0) begin
							add_char(random_letter());
							add_char(random_operator());
						end
						add_char(ifp_pkg::CH_LPAR);
					end
					add_expression();
				end
				default: begin
					send_idle_pct  = 15;
					recv_stall_pct = 15;
				end
			endcase
			while (item_count < PHASE_ITEMS) begin
				if ($urandom_range(3) == 0) begin
					add_broken();
				end else begin
					add_expression();
				end
			end
			wait_drained();
		end

		repeat (SETTLE_WAIT) @(posedge clk);
		mismatch_count += results_due.size();
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/ifp_pkg.sv
design/ifp_infix_if.sv
design/ifp_postfix_if.sv
design/ifp_stack_mem.sv
design/ifp_out_stage.sv
design/infix_to_postfix_converter.sv
design/ifp_checker.sv
verif/testbench.sv
